/* rtl/assert_macros.svh */
// assertion macros for the checker file
// no dependencies; include once per file that asserts
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define COR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("circle rasterizer check failed");

// next-cycle implication, disabled during reset
`define COR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("circle rasterizer check failed");

`endif

/* rtl/cor_pkg.sv */
// shared constants and codes for the circle outline rasterizer
// no dependencies
`default_nettype none

package cor_pkg;

  // frame size registers are fixed at 13 bits
  localparam int DIM_BITS      = 13;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 2;

  localparam logic [DIM_BITS-1:0] FRAME_WIDTH_RST  = 13'd640;
  localparam logic [DIM_BITS-1:0] FRAME_HEIGHT_RST = 13'd480;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_PIXEL_COLOR  = 2'd2
  } cfg_index_t;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } opcode_t;

endpackage : cor_pkg

`default_nettype wire

/* rtl/cor_cmd_if.sv */
// command channel: start / step items with circle center and radius
// depends on cor_pkg
`default_nettype none

interface cor_cmd_if #(
  parameter int COORD_BITS = 12
);
  logic                         valid;
  logic                         ready;
  cor_pkg::opcode_t             opcode;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic        [COORD_BITS-2:0] radius;

  modport source (output valid, opcode, center_x, center_y, radius, input ready);
  modport sink   (input valid, opcode, center_x, center_y, radius, output ready);
endinterface : cor_cmd_if

`default_nettype wire

/* rtl/cor_pix_if.sv */
// pixel channel: one clamped outline pixel per beat
// no dependencies
`default_nettype none

interface cor_pix_if #(
  parameter int COORD_BITS = 12
);
  logic                       valid;
  logic                       ready;
  logic signed [COORD_BITS:0] pixel_x;
  logic signed [COORD_BITS:0] pixel_y;
  logic                       last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last, output ready);
endinterface : cor_pix_if

`default_nettype wire

/* rtl/circle_outline_rasterizer_top.sv */
// midpoint circle outline rasterizer, top level
// depends on cor_pkg, cor_cmd_if, cor_pix_if
`default_nettype none

//  channel | dir | payload                              | beat
//  --------+-----+--------------------------------------+-------------------------------
//  cmd     | in  | opcode, center_x, center_y, radius   | one start or step item
//  pix     | out | pixel_x, pixel_y, last               | one mirrored outline pixel
//  cfg     | in  | cfg_we, cfg_index, cfg_data          | one register write, no wait
//
//  a step item is accepted and yields four pixel beats, one per cycle while pix is ready;
//  the single pixel port thus limits how often steps can be taken
//  a start item or a step while idle yields no beat
//  the next step is taken on the cycle the fourth beat leaves, so with a step waiting the port never idles
//  rst is synchronous: idle, offsets cleared, frame 640 x 480, color 0
//  a stall on pix holds the current beat; cmd waits only while beats are queued

module circle_outline_rasterizer_top #(
  parameter int COORD_BITS = 12
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire  [cor_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire  [cor_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  cor_cmd_if.sink                             cmd,
  cor_pix_if.source                           pix
);
  import cor_pkg::*;

  localparam int OFFX_BITS = COORD_BITS;
  localparam int OFFY_BITS = COORD_BITS + 1;
  localparam int ERR_BITS  = COORD_BITS + 3;
  localparam int PIX_BITS  = COORD_BITS + 1;
  localparam int SUM_BITS  = COORD_BITS + 2;
  localparam int CHK_BITS  = COORD_BITS + 6;
  // wide enough for both the raw sums and the frame limit (may be -1)
  localparam int CMP_BITS  = (SUM_BITS + 1 > DIM_BITS + 2) ? SUM_BITS + 1 : DIM_BITS + 2;

  // configuration registers
  logic [DIM_BITS-1:0]      frame_width;
  logic [DIM_BITS-1:0]      frame_height;
  // stored but not driven onto any port; does not enter the coordinates
  logic [CFG_DATA_BITS-1:0] pixel_color;

  // circle state
  logic                         active;
  logic signed [COORD_BITS-1:0] circle_center_x;
  logic signed [COORD_BITS-1:0] circle_center_y;
  logic        [OFFX_BITS-1:0]  offset_x;
  logic signed [OFFY_BITS-1:0]  offset_y;
  logic signed [ERR_BITS-1:0]   error_term;

  // pixel queue: the four mirrored coordinates of the last step
  logic                        pend;
  logic [1:0]                  beat_idx;
  logic        [PIX_BITS-1:0]  q_xp;
  logic        [PIX_BITS-1:0]  q_xm;
  logic        [PIX_BITS-1:0]  q_yp;
  logic        [PIX_BITS-1:0]  q_ym;
  logic                        q_fin;

  logic cmd_fire;
  logic pix_fire;
  logic last_beat;
  logic is_step;

  // ---------------- handshake ----------------
  assign last_beat = (beat_idx == 2'd3);
  assign pix_fire  = pix.valid && pix.ready;
  // queue frees on the fourth beat, so the next item can slide in behind it
  assign cmd.ready = !pend || (last_beat && pix.ready);
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign is_step   = (cmd.opcode == OP_STEP) && active;

  assign pix.valid   = pend;
  assign pix.pixel_x = beat_idx[1] ? q_xm : q_xp;
  assign pix.pixel_y = beat_idx[0] ? q_ym : q_yp;
  assign pix.last    = q_fin && last_beat;

  // ---------------- mirrored coordinates and clamps ----------------
  logic signed [SUM_BITS-1:0] xp_sum, xm_sum, yp_sum, ym_sum;
  logic signed [CMP_BITS-1:0] xp_ext, yp_ext, w_lim, h_lim, xp_cl, yp_cl;
  logic        [PIX_BITS-1:0] xp_pix, xm_pix, yp_pix, ym_pix;

  always_comb begin
    xp_sum = {{2{circle_center_x[COORD_BITS-1]}}, circle_center_x} + {2'b00, offset_x};
    xm_sum = {{2{circle_center_x[COORD_BITS-1]}}, circle_center_x} - {2'b00, offset_x};
    yp_sum = {{2{circle_center_y[COORD_BITS-1]}}, circle_center_y}
             + {offset_y[OFFY_BITS-1], offset_y};
    ym_sum = {{2{circle_center_y[COORD_BITS-1]}}, circle_center_y}
             - {offset_y[OFFY_BITS-1], offset_y};

    xp_ext = {{(CMP_BITS-SUM_BITS){xp_sum[SUM_BITS-1]}}, xp_sum};
    yp_ext = {{(CMP_BITS-SUM_BITS){yp_sum[SUM_BITS-1]}}, yp_sum};
    // a frame size of zero gives a limit of -1, used as is
    w_lim  = $signed({{(CMP_BITS-DIM_BITS){1'b0}}, frame_width}) - CMP_BITS'(1);
    h_lim  = $signed({{(CMP_BITS-DIM_BITS){1'b0}}, frame_height}) - CMP_BITS'(1);
    xp_cl  = (xp_ext > w_lim) ? w_lim : xp_ext;
    yp_cl  = (yp_ext > h_lim) ? h_lim : yp_ext;

    xp_pix = xp_cl[PIX_BITS-1:0];
    yp_pix = yp_cl[PIX_BITS-1:0];
    // minus side clamps at the frame origin
    xm_pix = xm_sum[SUM_BITS-1] ? '0 : xm_sum[PIX_BITS-1:0];
    ym_pix = ym_sum[SUM_BITS-1] ? '0 : ym_sum[PIX_BITS-1:0];
  end

  // ---------------- midpoint error rule ----------------
  logic signed [CHK_BITS-1:0]  chk;
  logic signed [ERR_BITS-1:0]  x1_e, y1_e;
  logic signed [OFFY_BITS-1:0] y1;
  logic                        d_neg, d_pos, chk_le0;
  logic        [OFFX_BITS-1:0] offset_x_next;
  logic signed [OFFY_BITS-1:0] offset_y_next;
  logic signed [ERR_BITS-1:0]  error_term_next;
  logic signed [ERR_BITS-1:0]  start_err;

  always_comb begin
    chk = (({{(CHK_BITS-ERR_BITS){error_term[ERR_BITS-1]}}, error_term}
          + {{(CHK_BITS-OFFY_BITS){offset_y[OFFY_BITS-1]}}, offset_y}) <<< 1)
          - CHK_BITS'(1);
    d_neg   = error_term[ERR_BITS-1];
    d_pos   = !d_neg && (error_term != '0);
    chk_le0 = chk[CHK_BITS-1] || (chk == '0);

    // x + 1 kept unwrapped for the error update, wrapped only when stored
    x1_e = {{(ERR_BITS-OFFX_BITS){1'b0}}, offset_x} + ERR_BITS'(1);
    y1   = offset_y - OFFY_BITS'(1);
    y1_e = {{(ERR_BITS-OFFY_BITS){y1[OFFY_BITS-1]}}, y1};

    priority if (d_neg && chk_le0) begin
      // move right only
      offset_x_next   = x1_e[OFFX_BITS-1:0];
      offset_y_next   = offset_y;
      error_term_next = error_term + (x1_e <<< 1) + ERR_BITS'(1);
    end else if (d_pos && !chk_le0) begin
      // move down only
      offset_x_next   = offset_x;
      offset_y_next   = y1;
      error_term_next = error_term - ((y1_e <<< 1) + ERR_BITS'(1));
    end else begin
      // diagonal
      offset_x_next   = x1_e[OFFX_BITS-1:0];
      offset_y_next   = y1;
      error_term_next = error_term + ((x1_e - y1_e) <<< 1);
    end

    start_err = ERR_BITS'(1) - ({{(ERR_BITS-COORD_BITS+1){1'b0}}, cmd.radius} <<< 1);
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
      pixel_color  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_BITS-1:0];
        CFG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_BITS-1:0];
        CFG_PIXEL_COLOR:  pixel_color  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      circle_center_x <= '0;
      circle_center_y <= '0;
      offset_x        <= '0;
      offset_y        <= '0;
      error_term      <= '0;
    end else if (cmd_fire) begin
      if (cmd.opcode == OP_START) begin
        // start abandons any running circle
        active          <= 1'b1;
        circle_center_x <= cmd.center_x;
        circle_center_y <= cmd.center_y;
        offset_x        <= '0;
        offset_y        <= {2'b00, cmd.radius};
        error_term      <= start_err;
      end else if (is_step) begin
        offset_x   <= offset_x_next;
        offset_y   <= offset_y_next;
        error_term <= error_term_next;
        // circle ends once y has crossed below zero
        if (offset_y_next[OFFY_BITS-1]) begin
          active <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend     <= 1'b0;
      beat_idx <= '0;
    end else begin
      if (pix_fire) begin
        beat_idx <= beat_idx + 2'd1;
        if (last_beat) begin
          pend <= 1'b0;
        end
      end
      if (cmd_fire && is_step) begin
        pend     <= 1'b1;
        beat_idx <= '0;
      end
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk) begin
    if (cmd_fire && is_step) begin
      q_xp  <= xp_pix;
      q_xm  <= xm_pix;
      q_yp  <= yp_pix;
      q_ym  <= ym_pix;
      q_fin <= offset_y_next[OFFY_BITS-1];
    end
  end

endmodule : circle_outline_rasterizer_top

`default_nettype wire

/* rtl/cor_checker.sv */
// port-level checks for the circle outline rasterizer, with its bind
// depends on cor_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module cor_checker (
  input wire clk,
  input wire rst,
  input wire cmd_valid,
  input wire cmd_ready,
  input wire cmd_opcode,
  input wire pix_valid,
  input wire pix_ready
);
  import cor_pkg::*;

  logic cmd_fire;
  logic start_fire;

  assign cmd_fire   = cmd_valid && cmd_ready;
  assign start_fire = cmd_fire && (cmd_opcode == OP_START);

  // a queued beat is not dropped while stalled
  `COR_ASSERT_NEXT(a_pix_hold, clk, rst, pix_valid && !pix_ready, pix_valid)
  // cmd only waits behind queued beats
  `COR_ASSERT_NOW(a_cmd_wait, clk, rst, !cmd_ready, pix_valid)
  // an item is taken over a busy queue only while a beat leaves
  `COR_ASSERT_NOW(a_cmd_overlap, clk, rst, cmd_fire && pix_valid, pix_ready)
  // a start on an empty queue yields no beat
  `COR_ASSERT_NEXT(a_start_quiet, clk, rst, start_fire && !pix_valid, !pix_valid)

endmodule : cor_checker

bind circle_outline_rasterizer_top cor_checker u_cor_checker (
  .clk        (clk),
  .rst        (rst),
  .cmd_valid  (cmd.valid),
  .cmd_ready  (cmd.ready),
  .cmd_opcode (cmd.opcode),
  .pix_valid  (pix.valid),
  .pix_ready  (pix.ready)
);

`default_nettype wire
